/* design/mbc1_pkg.sv */
// Package for the MBC1-style bank controller: beat types, command codes,
// address-region codes and default sizes. No dependencies.
`timescale 1ns / 1ps

package mbc1_pkg;

  localparam int RAM_DEPTH_DEF     = 32768;
  localparam int ROM_BANK_BITS_DEF = 7;
  localparam int RAM_IDX_W         = 15;  // bank * 8 KB + offset, before wrapping

  localparam logic [7:0] ENABLE_BITS   = 8'h0A;
  localparam logic [4:0] LOW_BANK_ZERO = 5'd0;

  // Address regions, keyed by address bits 15:13.
  localparam logic [2:0] REG_RAM_EN   = 3'b000;
  localparam logic [2:0] REG_ROM_LOW  = 3'b001;
  localparam logic [2:0] REG_BANK2    = 3'b010;
  localparam logic [2:0] REG_MODE     = 3'b011;
  localparam logic [2:0] REG_CART_RAM = 3'b101;

  // Command codes passed from the front to the back.
  localparam logic [1:0] CMD_ZERO   = 2'd0;
  localparam logic [1:0] CMD_ROM    = 2'd1;
  localparam logic [1:0] CMD_RAM_RD = 2'd2;
  localparam logic [1:0] CMD_RAM_WR = 2'd3;

  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  write_data;
  } access_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        rom_hit;
    logic [20:0] rom_address;
  } result_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [RAM_IDX_W-1:0] ram_index;
    logic [7:0]           write_data;
    logic [20:0]          rom_address;
  } cmd_t;

endpackage

/* design/mbc1_front.sv */
// Front end: accepts bus beats, updates the bank registers in order and
// turns each beat into a command for the back end. Depends on mbc1_pkg.
`timescale 1ns / 1ps

module mbc1_front #(
  parameter int RAM_DEPTH     = mbc1_pkg::RAM_DEPTH_DEF,
  parameter int ROM_BANK_BITS = mbc1_pkg::ROM_BANK_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mbc1_pkg::access_t access,
  input  logic              cmd_full,
  output logic              cmd_push,
  output mbc1_pkg::cmd_t    cmd
);
  import mbc1_pkg::*;

  logic [ROM_BANK_BITS-1:0] rom_bank, rom_bank_next;
  logic [1:0]               ram_bank, ram_bank_next;
  logic                     ram_on, ram_on_next;
  logic                     ram_mode, ram_mode_next;

  logic [2:0]  region;
  logic [6:0]  bank7;
  logic [6:0]  bank7_new;
  logic [4:0]  low_bits;
  logic [15:0] wrap;

  assign cmd_push = push && !cmd_full;
  assign region   = access.address[15:13];
  assign bank7    = 7'(rom_bank);

  always_comb begin
    rom_bank_next = rom_bank;
    ram_bank_next = ram_bank;
    ram_on_next   = ram_on;
    ram_mode_next = ram_mode;
    bank7_new     = bank7;
    low_bits      = access.write_data[4:0];
    if (low_bits == LOW_BANK_ZERO) begin
      low_bits = 5'd1;
    end
    if (access.kind == KIND_WRITE) begin
      case (region)
        REG_RAM_EN: begin
          ram_on_next = (access.write_data & ENABLE_BITS) == ENABLE_BITS;
        end
        REG_ROM_LOW: begin
          bank7_new = {bank7[6:5], low_bits};
        end
        REG_BANK2: begin
          if (ram_mode) begin
            ram_bank_next = access.write_data[1:0];
          end else begin
            bank7_new = {access.write_data[1:0], bank7[4:0]};
          end
        end
        REG_MODE: begin
          ram_mode_next = access.write_data != 8'd0;
        end
        default: begin
        end
      endcase
    end
    rom_bank_next = bank7_new[ROM_BANK_BITS-1:0];
  end

  // Bank * 8 KB + offset is below four times the smallest depth, so three
  // conditional subtractions wrap it into the RAM.
  always_comb begin
    wrap = {1'b0, ram_bank, access.address[12:0]};
    for (int i = 0; i < 3; i++) begin
      if (wrap >= 16'(RAM_DEPTH)) begin
        wrap = wrap - 16'(RAM_DEPTH);
      end
    end
  end

  always_comb begin
    cmd.op          = CMD_ZERO;
    cmd.ram_index   = wrap[RAM_IDX_W-1:0];
    cmd.write_data  = access.write_data;
    cmd.rom_address = 21'd0;
    if (access.kind == KIND_WRITE) begin
      if (region == REG_CART_RAM) begin
        cmd.op = CMD_RAM_WR;
      end
    end else if (!access.address[15]) begin
      cmd.op = CMD_ROM;
      if (!access.address[14]) begin
        cmd.rom_address = 21'(access.address);
      end else begin
        cmd.rom_address = (21'(rom_bank) << 14) | 21'(access.address[13:0]);
      end
    end else if (region == REG_CART_RAM && ram_on) begin
      cmd.op = CMD_RAM_RD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank <= ROM_BANK_BITS'(1);
      ram_bank <= 2'd0;
      ram_on   <= 1'b0;
      ram_mode <= 1'b0;
    end else if (cmd_push) begin
      rom_bank <= rom_bank_next;
      ram_bank <= ram_bank_next;
      ram_on   <= ram_on_next;
      ram_mode <= ram_mode_next;
    end
  end

endmodule

/* design/mbc1_cmd_queue.sv */
// Two-entry command queue between the front and back ends.
// Depends on mbc1_pkg for the command type.
`timescale 1ns / 1ps

module mbc1_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mbc1_pkg::cmd_t cmd_in,
  output logic           full,
  output logic           empty,
  input  logic           pop,
  output mbc1_pkg::cmd_t cmd_out
);
  import mbc1_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign cmd_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

/* design/mbc1_back.sv */
// Back end: cartridge RAM access, result formation and a two-entry result
// queue. Depends on mbc1_pkg.
`timescale 1ns / 1ps

module mbc1_back #(
  parameter int RAM_DEPTH = mbc1_pkg::RAM_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_empty,
  input  mbc1_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  output logic              empty,
  input  logic              pop,
  output mbc1_pkg::result_t result
);
  import mbc1_pkg::*;

  localparam int RAM_AW = $clog2(RAM_DEPTH);

  logic [7:0]        cart_ram [RAM_DEPTH];
  logic [RAM_AW-1:0] ram_addr;
  logic [7:0]        ram_q;

  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [20:0] s1_rom_address;
  result_t     s1_result;

  result_t    oq [2];
  logic       oq_wr;
  logic       oq_rd;
  logic [1:0] oq_count;
  logic [1:0] occupancy;
  logic       pop_fire;

  assign pop_fire  = pop && !empty;
  assign occupancy = oq_count + {1'b0, s1_valid};
  // Issue only when the beat in flight and the queued results leave room.
  assign cmd_pop   = !cmd_empty &&
                     (occupancy < 2'd2 || (occupancy == 2'd2 && pop_fire));
  assign ram_addr  = cmd.ram_index[RAM_AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op == CMD_RAM_WR) begin
      cart_ram[ram_addr] <= cmd.write_data;
    end
    if (cmd_pop) begin
      ram_q <= cart_ram[ram_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_op          <= cmd.op;
      s1_rom_address <= cmd.rom_address;
    end
  end

  always_comb begin
    s1_result.read_data   = (s1_op == CMD_RAM_RD) ? ram_q : 8'd0;
    s1_result.rom_hit     = s1_op == CMD_ROM;
    s1_result.rom_address = s1_rom_address;
  end

  assign empty  = oq_count == 2'd0;
  assign result = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      oq[oq_wr] <= s1_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      oq_wr    <= 1'b0;
      oq_rd    <= 1'b0;
      oq_count <= 2'd0;
    end else begin
      s1_valid <= cmd_pop;
      if (s1_valid) begin
        oq_wr <= ~oq_wr;
      end
      if (pop_fire) begin
        oq_rd <= ~oq_rd;
      end
      oq_count <= oq_count + {1'b0, s1_valid} - {1'b0, pop_fire};
    end
  end

endmodule

/* design/mbc1_bank_controller.sv */
// Channel  | Handshake            | Beat
// access   | push / full          | kind, address, write_data
// result   | pop / empty          | read_data, rom_hit, rom_address
//
// One access is taken per cycle while full is low; a result shows on the result
// port once its access has passed the command queue, the RAM read register and
// the result queue, and it can be popped from the next edge on. The single-port
// cartridge RAM handles one access per cycle while the back end issues commands.
// Reset clears the bank registers and queues; RAM contents are kept.
// A stalled result port fills the result and command queues, then raises full.
// Top level; depends on mbc1_pkg, mbc1_front, mbc1_cmd_queue and mbc1_back.
`timescale 1ns / 1ps

module mbc1_bank_controller #(
  parameter int RAM_DEPTH     = mbc1_pkg::RAM_DEPTH_DEF,
  parameter int ROM_BANK_BITS = mbc1_pkg::ROM_BANK_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  mbc1_pkg::access_t access,
  output logic              empty,
  input  logic              pop,
  output mbc1_pkg::result_t result
);
  import mbc1_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic front_push;
  logic cq_full;
  logic cq_empty;
  logic cq_pop;

  assign full = cq_full;

  mbc1_front #(
    .RAM_DEPTH     (RAM_DEPTH),
    .ROM_BANK_BITS (ROM_BANK_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .access   (access),
    .cmd_full (cq_full),
    .cmd_push (front_push),
    .cmd      (front_cmd)
  );

  mbc1_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (front_push),
    .cmd_in  (front_cmd),
    .full    (cq_full),
    .empty   (cq_empty),
    .pop     (cq_pop),
    .cmd_out (back_cmd)
  );

  mbc1_back #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cq_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cq_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

/* design/mbc1_checker.sv */
// Port-level checks for the bank controller, attached by bind.
// Depends on mbc1_pkg and mbc1_bank_controller.
`timescale 1ns / 1ps

module mbc1_checker (
  input logic              clk,
  input logic              rst,
  input logic              push,
  input logic              full,
  input mbc1_pkg::access_t access,
  input logic              empty,
  input logic              pop,
  input mbc1_pkg::result_t result
);
  import mbc1_pkg::*;

  // Reset drains both queues.
  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared by reset");

  // A ROM beat never carries RAM data.
  a_rom_no_data: assert property (@(posedge clk) disable iff (rst)
    !empty && result.rom_hit |-> result.read_data == 8'd0)
    else $error("ROM result carries read data");

  // Only ROM beats carry a ROM address.
  a_addr_only_rom: assert property (@(posedge clk) disable iff (rst)
    !empty && !result.rom_hit |-> result.rom_address == 21'd0)
    else $error("non-ROM result carries a ROM address");

  // A result that is not taken stays put.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("stalled result changed");

endmodule

bind mbc1_bank_controller mbc1_checker u_checker (.*);

/* dv/mbc1_bank_controller_tb.sv */
// Self-checking testbench for mbc1_bank_controller: queued bus accesses, a bank predictor
// and an in-order check of every result beat. Depends on mbc1_pkg and the RTL top.
`timescale 1ns / 1ps

module mbc1_bank_controller_tb;
  import mbc1_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_PCT     = 14;
  localparam int DRAIN_CYCLES = 10;
  localparam int BANK_BYTES   = 8192;
  localparam int RAM_BANKS    = 4;
  localparam logic KIND_READ  = !KIND_WRITE;

  logic    clk     = 1'b0;
  logic    rst     = 1'b1;
  logic    push    = 1'b0;
  logic    pop     = 1'b0;
  logic    calm    = 1'b0;
  logic    hold_go = 1'b0;
  logic    full;
  logic    empty;
  access_t access  = '0;
  result_t result;

  mbc1_bank_controller uut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .access (access),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #HALF_PERIOD clk = ~clk;

  access_t pending_accesses[$];
  result_t awaited_results[$];
  access_t taken_access;
  result_t taken_result;

  // Predicted controller state.
  logic [6:0] mdl_rom_bank;
  logic [1:0] mdl_ram_bank;
  logic       mdl_ram_on;
  logic       mdl_ram_mode;
  logic [7:0] cart_mem [RAM_DEPTH_DEF];

  // Stimulus-side view of banking, used only to keep RAM reads on stored bytes.
  logic       plan_mode = 1'b0;
  logic [1:0] plan_bank = 2'd0;
  bit         plan_written [RAM_DEPTH_DEF];
  logic [12:0] filled_off [RAM_BANKS][BANK_BYTES];
  int         filled_cnt [RAM_BANKS];

  int errors = 0;
  int queued = 0;
  int accepted = 0;
  int checked = 0;
  int rom_reads = 0;
  int ram_reads = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  logic hold_taken = 1'b0;

  function automatic logic idle_now();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  function automatic result_t predict_access(access_t a);
    result_t r;
    logic [4:0] low;
    int idx;
    r = '0;
    idx = (int'(mdl_ram_bank) * BANK_BYTES + int'(a.address[12:0])) % RAM_DEPTH_DEF;
    if (a.kind == KIND_WRITE) begin
      case (a.address[15:13])
        REG_RAM_EN: mdl_ram_on = ((a.write_data & ENABLE_BITS) == ENABLE_BITS);
        REG_ROM_LOW: begin
          low = a.write_data[4:0];
          if (low == LOW_BANK_ZERO) low = 5'd1;
          mdl_rom_bank[4:0] = low;
        end
        REG_BANK2: begin
          if (mdl_ram_mode) mdl_ram_bank = a.write_data[1:0];
          else mdl_rom_bank[6:5] = a.write_data[1:0];
        end
        REG_MODE: mdl_ram_mode = (a.write_data != 8'd0);
        REG_CART_RAM: cart_mem[idx] = a.write_data;
        default: ;
      endcase
    end else if (!a.address[15]) begin
      r.rom_hit = 1'b1;
      if (a.address[14]) r.rom_address = {mdl_rom_bank, a.address[13:0]};
      else r.rom_address = 21'(a.address);
    end else if (a.address[15:13] == REG_CART_RAM && mdl_ram_on) begin
      r.read_data = cart_mem[idx];
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("%0t: mismatch on %s at beat %0d: got %h, expected %h",
               $time, what, checked, got, want);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (awaited_results.size() == 0) begin
      flag_mismatch("unexpected result", 32'(got), 32'd0);
      return;
    end
    want = awaited_results.pop_front();
    checked++;
    if (got.read_data !== want.read_data)
      flag_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
    if (got.rom_hit !== want.rom_hit)
      flag_mismatch("rom_hit", 32'(got.rom_hit), 32'(want.rom_hit));
    if (got.rom_address !== want.rom_address)
      flag_mismatch("rom_address", 32'(got.rom_address), 32'(want.rom_address));
  endtask

  task automatic queue_access(input logic kind, input logic [15:0] addr,
                              input logic [7:0] data);
    access_t a;
    int idx;
    a.kind = kind;
    a.address = addr;
    a.write_data = data;
    idx = int'(plan_bank) * BANK_BYTES + int'(addr[12:0]);
    // A RAM read of a byte never stored is turned into a store of that byte.
    if (addr[15:13] == REG_CART_RAM && kind != KIND_WRITE && !plan_written[idx])
      a.kind = KIND_WRITE;
    if (a.kind == KIND_WRITE) begin
      case (addr[15:13])
        REG_BANK2: if (plan_mode) plan_bank = data[1:0];
        REG_MODE: plan_mode = (data != 8'd0);
        REG_CART_RAM: begin
          if (!plan_written[idx]) begin
            plan_written[idx] = 1'b1;
            filled_off[plan_bank][filled_cnt[plan_bank]] = addr[12:0];
            filled_cnt[plan_bank]++;
          end
        end
        default: ;
      endcase
    end
    pending_accesses.push_back(a);
    queued++;
  endtask

  function automatic logic [15:0] hot_ram_addr();
    logic [12:0] off;
    case ($urandom_range(2))
      0: off = 13'($urandom_range(31));
      1: off = 13'(BANK_BYTES - 1 - $urandom_range(31));
      default: off = 13'($urandom);
    endcase
    return {REG_CART_RAM, off};
  endfunction

  function automatic logic [15:0] filled_ram_addr();
    if (filled_cnt[plan_bank] == 0) return {REG_CART_RAM, 13'($urandom)};
    return {REG_CART_RAM, filled_off[plan_bank][$urandom_range(filled_cnt[plan_bank] - 1)]};
  endfunction

  task automatic ram_session();
    logic [7:0] v;
    v = 8'($urandom);
    queue_access(KIND_WRITE, {REG_RAM_EN, 13'($urandom)},
                 ($urandom_range(3) != 0) ? (v | ENABLE_BITS) : v);
    if ($urandom_range(1)) begin
      queue_access(KIND_WRITE, {REG_MODE, 13'($urandom)}, 8'($urandom_range(1, 255)));
      queue_access(KIND_WRITE, {REG_BANK2, 13'($urandom)}, 8'($urandom));
    end
    repeat ($urandom_range(4, 14)) begin
      if ($urandom_range(1)) queue_access(KIND_WRITE, hot_ram_addr(), 8'($urandom));
      else queue_access(KIND_READ, filled_ram_addr(), 8'($urandom));
    end
  endtask

  task automatic rom_session();
    logic [7:0] v;
    v = 8'($urandom);
    if ($urandom_range(5) == 0) v[4:0] = LOW_BANK_ZERO;
    queue_access(KIND_WRITE, {REG_ROM_LOW, 13'($urandom)}, v);
    if ($urandom_range(1)) queue_access(KIND_WRITE, {REG_BANK2, 13'($urandom)}, 8'($urandom));
    if ($urandom_range(3) == 0)
      queue_access(KIND_WRITE, {REG_MODE, 13'($urandom)},
                   $urandom_range(1) ? 8'($urandom) : 8'd0);
    repeat ($urandom_range(3, 10)) queue_access(KIND_READ, {1'b0, 15'($urandom)}, 8'($urandom));
  endtask

  task automatic random_items(input int n);
    int target;
    target = queued + n;
    while (queued < target) begin
      case ($urandom_range(9))
        0, 1, 2, 3: ram_session();
        4, 5, 6: rom_session();
        default: queue_access(1'($urandom), 16'($urandom), 8'($urandom));
      endcase
    end
  endtask

  task automatic wait_drained();
    while (pending_accesses.size() != 0 || awaited_results.size() != 0) @(posedge clk);
  endtask

  // Access driver: one beat offered from the head of the pending queue.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      mdl_rom_bank = 7'd1;
      mdl_ram_bank = 2'd0;
      mdl_ram_on = 1'b0;
      mdl_ram_mode = 1'b0;
    end else begin
      if (push && !full) begin
        taken_access = pending_accesses.pop_front();
        taken_result = predict_access(taken_access);
        awaited_results.push_back(taken_result);
        accepted++;
        if (taken_result.rom_hit) rom_reads++;
        if (taken_access.kind != KIND_WRITE && taken_access.address[15:13] == REG_CART_RAM
            && mdl_ram_on) ram_reads++;
        if (taken_access.kind == KIND_WRITE && !taken_access.address[15]) reg_writes++;
      end
      if (pending_accesses.size() != 0 && !idle_now()) begin
        push <= 1'b1;
        access <= pending_accesses[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result monitor, with its own count for the long output hold.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result(result);
      if (hold_go && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= LONG_HOLD;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      pop <= (hold_left == 0) && !(hold_go && !hold_taken) && !idle_now();
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) ||
        (pending_accesses.size() == 0 && awaited_results.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[mbc1_bank_controller] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ROM windows at reset, the zero bank fixup and the widest bank.
    queue_access(KIND_READ, 16'h0000, 8'h00);
    queue_access(KIND_READ, 16'h3FFF, 8'hFF);
    queue_access(KIND_READ, 16'h4000, 8'h00);
    queue_access(KIND_WRITE, 16'h2000, 8'h00);
    queue_access(KIND_READ, 16'h7FFF, 8'h00);
    queue_access(KIND_WRITE, 16'h3FFF, 8'hFF);
    queue_access(KIND_WRITE, 16'h4000, 8'h03);
    queue_access(KIND_READ, 16'h7FFF, 8'h00);
    // RAM mode, top bank; a store while disabled still lands.
    queue_access(KIND_WRITE, 16'h6000, 8'h01);
    queue_access(KIND_WRITE, 16'h5FFF, 8'h03);
    queue_access(KIND_WRITE, 16'hBFFF, 8'hA5);
    queue_access(KIND_READ, 16'hBFFF, 8'h00);
    queue_access(KIND_WRITE, 16'h0000, ENABLE_BITS);
    queue_access(KIND_READ, 16'hBFFF, 8'h00);
    queue_access(KIND_WRITE, 16'hA000, 8'hFF);
    queue_access(KIND_READ, 16'hA000, 8'h00);
    queue_access(KIND_WRITE, 16'h1FFF, 8'hF5);
    queue_access(KIND_READ, 16'hA000, 8'h00);
    // Unmapped space.
    queue_access(KIND_READ, 16'h8000, 8'h00);
    queue_access(KIND_WRITE, 16'h9FFF, 8'hFF);
    queue_access(KIND_READ, 16'hC000, 8'h00);
    queue_access(KIND_WRITE, 16'hFFFF, 8'h5A);
    queue_access(KIND_READ, 16'hFFFF, 8'hFF);
    // Back to ROM mode; the bank registers must keep their values.
    queue_access(KIND_WRITE, 16'h7FFF, 8'h00);
    queue_access(KIND_READ, 16'h4000, 8'h00);
    wait_drained();

    random_items(400);
    @(posedge clk);
    hold_go <= 1'b1;
    random_items(200);
    wait_drained();

    @(posedge clk);
    calm <= 1'b1;
    random_items(400);
    while (pending_accesses.size() != 0) @(posedge clk);
    calm <= 1'b0;

    random_items(800);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result beats from %0d accesses: %0d ROM reads, %0d enabled RAM reads,",
             checked, accepted, rom_reads, ram_reads);
    $display("%0d bank register writes, a %0d-cycle output hold and a full drain pause.",
             reg_writes, LONG_HOLD);
    if (errors == 0) begin
      $display("[mbc1_bank_controller] OK");
    end else begin
      $display("[mbc1_bank_controller] ERROR");
    end
    $finish;
  end

endmodule
